>>> rtl/cev_pkg.sv
package cev_pkg;

  // event kinds
  localparam logic [1:0] EV_NOTE_OFF = 2'd0;
  localparam logic [1:0] EV_NOTE_ON  = 2'd1;
  localparam logic [1:0] EV_KEY      = 2'd2;
  localparam logic [1:0] EV_MODE     = 2'd3;

  // play modes
  localparam logic [1:0] PM_DRUM   = 2'd0;
  localparam logic [1:0] PM_SINGLE = 2'd1;
  localparam logic [1:0] PM_TRIAD  = 2'd2;
  localparam logic [1:0] PM_POWER  = 2'd3;

  // scale tables
  localparam logic [1:0] SC_MAJOR = 2'd0;
  localparam logic [1:0] SC_MINOR = 2'd1;
  localparam logic [1:0] SC_PENTA = 2'd2;
  localparam logic [1:0] SC_EXTRA = 2'd3;

  // register indexes
  localparam logic CFG_PLAY_MODE = 1'b0;
  localparam logic CFG_SCALE     = 1'b1;

  localparam logic [6:0] KEY_LOW  = 7'd12;
  localparam logic [6:0] KEY_HIGH = 7'd110;
  localparam logic [6:0] KEY_HOME = 7'd60;

  // two's complement offsets and key steps, 8 bits
  localparam logic [7:0] OFS_OCT_DN    = 8'hF4;
  localparam logic [7:0] OFS_FIFTH_DN  = 8'hFB;
  localparam logic [7:0] DELTA_OCT_UP  = 8'd12;
  localparam logic [7:0] DELTA_SEMI_UP = 8'd1;
  localparam logic [7:0] DELTA_OCT_DN  = 8'hF4;
  localparam logic [7:0] DELTA_SEMI_DN = 8'hFF;

  localparam logic [4:0] SCALE_TAB [3][8] = '{
    '{5'd0, 5'd2, 5'd4, 5'd5, 5'd7,  5'd9,  5'd11, 5'd12},
    '{5'd0, 5'd2, 5'd3, 5'd5, 5'd7,  5'd8,  5'd10, 5'd12},
    '{5'd0, 5'd3, 5'd5, 5'd7, 5'd10, 5'd12, 5'd15, 5'd17}
  };

  localparam logic [6:0] DRUM_TAB [8] = '{
    7'd36, 7'd38, 7'd37, 7'd43, 7'd45, 7'd42, 7'd46, 7'd49
  };

  // scale degree of the third and fifth above each pad, wrapped into 0..6
  localparam logic [2:0] THIRD_POS [8] = '{
    3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd0, 3'd1, 3'd2
  };
  localparam logic [2:0] FIFTH_POS [8] = '{
    3'd4, 3'd5, 3'd6, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4
  };

  typedef struct packed {
    logic [7:0] pads_pressed;
    logic       mode_pad;
  } in_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [6:0] note_number;
    logic       last_event;
  } out_t;

  // request to the shared adder
  typedef struct packed {
    logic       op_note;
    logic [7:0] delta;
    logic [2:0] pad;
    logic [1:0] step;
    logic [1:0] play_mode;
    logic [1:0] scale;
    logic [6:0] key;
  } alu_req_t;

  typedef struct packed {
    logic [6:0] value;
    logic       in_range;
    logic [1:0] last_step;
  } alu_rsp_t;

  // scale code three reads the pentatonic table
  function automatic logic [1:0] scale_idx(input logic [1:0] s);
    return (s == SC_EXTRA) ? SC_PENTA : s;
  endfunction

endpackage

>>> rtl/cev_alu.sv
module cev_alu (
  input  cev_pkg::alu_req_t req,
  output cev_pkg::alu_rsp_t rsp
);
  import cev_pkg::*;

  logic [2:0] tp;
  logic [2:0] fp;
  logic [4:0] root_ofs;
  logic [4:0] third_ofs;
  logic [4:0] fifth_ofs;
  logic [6:0] base;
  logic [7:0] operand;
  logic [8:0] sum;
  logic       triad;

  always_comb begin
    tp        = THIRD_POS[req.pad];
    fp        = FIFTH_POS[req.pad];
    root_ofs  = SCALE_TAB[req.scale][req.pad];
    // degrees below the pad sit an octave up
    third_ofs = SCALE_TAB[req.scale][tp] + ((req.pad > tp) ? 5'd12 : 5'd0);
    fifth_ofs = SCALE_TAB[req.scale][fp] + ((req.pad > fp) ? 5'd12 : 5'd0);
    triad     = (req.play_mode == PM_TRIAD) && (req.scale != SC_PENTA);

    base          = req.key;
    operand       = {3'b000, root_ofs};
    rsp.last_step = 2'd0;

    if (!req.op_note) begin
      operand = req.delta;
    end else begin
      case (req.play_mode)
        PM_DRUM: begin
          base    = 7'd0;
          operand = {1'b0, DRUM_TAB[req.pad]};
        end
        PM_POWER: begin
          rsp.last_step = 2'd2;
          case (req.step)
            2'd0:    operand = {3'b000, root_ofs} + OFS_OCT_DN;
            2'd1:    operand = {3'b000, root_ofs} + OFS_FIFTH_DN;
            default: operand = {3'b000, root_ofs};
          endcase
        end
        default: begin
          if (triad) begin
            rsp.last_step = 2'd3;
            case (req.step)
              2'd0:    operand = {3'b000, root_ofs} + OFS_OCT_DN;
              2'd1:    operand = {3'b000, third_ofs} + OFS_OCT_DN;
              2'd2:    operand = {3'b000, fifth_ofs} + OFS_OCT_DN;
              default: operand = {3'b000, root_ofs};
            endcase
          end
        end
      endcase
    end

    sum          = {2'b00, base} + {operand[7], operand};
    rsp.value    = sum[6:0];
    rsp.in_range = !sum[8] && (sum[7:0] >= {1'b0, KEY_LOW}) &&
                   (sum[7:0] <= {1'b0, KEY_HIGH});
  end

endmodule

>>> rtl/cev_seq.sv
module cev_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cev_pkg::in_t      in_data,
  input  logic [1:0]        play_mode,
  input  logic [1:0]        scale,
  input  logic              slot_free,
  output logic              emit,
  output cev_pkg::out_t     emit_data,
  output cev_pkg::alu_req_t alu_req,
  input  cev_pkg::alu_rsp_t alu_rsp
);
  import cev_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECIDE = 2'd1;
  localparam logic [1:0] ST_RUN    = 2'd2;

  logic [1:0] state_r, state_nxt;
  in_t        frame_r, frame_nxt;
  logic [6:0] key_r, key_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic [1:0] step_r, step_nxt;

  logic [7:0] pads;
  logic [7:0] diff;
  logic [2:0] pad_sel;
  logic [7:0] rest;
  logic       combo;
  logic [7:0] delta;
  logic [6:0] new_key;

  always_comb begin
    pads = frame_r.pads_pressed;
    diff = pads ^ prev_r;

    // lowest pending pad
    pad_sel = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (pend_r[i]) pad_sel = 3'(i);
    end
    rest = pend_r & ~(8'b1 << pad_sel);

    combo = 1'b1;
    if (pads[7:4] == 4'hF)      delta = DELTA_OCT_UP;
    else if (pads[7:5] == 3'h7) delta = DELTA_SEMI_UP;
    else if (pads[3:0] == 4'hF) delta = DELTA_OCT_DN;
    else if (pads[2:0] == 3'h7) delta = DELTA_SEMI_DN;
    else begin
      combo = 1'b0;
      delta = 8'd0;
    end

    alu_req.op_note   = (state_r == ST_RUN);
    alu_req.delta     = delta;
    alu_req.pad       = pad_sel;
    alu_req.step      = step_r;
    alu_req.play_mode = play_mode;
    alu_req.scale     = scale;
    alu_req.key       = key_r;

    new_key = (play_mode == PM_DRUM) ? KEY_HOME : alu_rsp.value;
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    frame_nxt = frame_r;
    key_nxt   = key_r;
    prev_nxt  = prev_r;
    pend_nxt  = pend_r;
    step_nxt  = step_r;
    emit      = 1'b0;
    emit_data = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          frame_nxt = in_data;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (frame_r.mode_pad) begin
          if (slot_free) begin
            emit                 = 1'b1;
            emit_data.event_kind = EV_MODE;
            emit_data.last_event = 1'b1;
            state_nxt            = ST_IDLE;
          end
        end else if (combo) begin
          if (!alu_rsp.in_range) begin
            state_nxt = ST_IDLE;
          end else if (slot_free) begin
            key_nxt               = new_key;
            emit                  = 1'b1;
            emit_data.event_kind  = EV_KEY;
            emit_data.note_number = new_key;
            emit_data.last_event  = 1'b1;
            state_nxt             = ST_IDLE;
          end
        end else begin
          prev_nxt  = pads;
          pend_nxt  = diff;
          step_nxt  = 2'd0;
          state_nxt = (diff == 8'd0) ? ST_IDLE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (slot_free) begin
          emit                  = 1'b1;
          emit_data.event_kind  = pads[pad_sel] ? EV_NOTE_ON : EV_NOTE_OFF;
          emit_data.note_number = alu_rsp.value;
          emit_data.last_event  = (step_r == alu_rsp.last_step) && (rest == 8'd0);
          if (step_r == alu_rsp.last_step) begin
            pend_nxt = rest;
            step_nxt = 2'd0;
            if (rest == 8'd0) state_nxt = ST_IDLE;
          end else begin
            step_nxt = step_r + 2'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      key_r   <= KEY_HOME;
      prev_r  <= 8'd0;
      pend_r  <= 8'd0;
      step_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      key_r   <= key_nxt;
      prev_r  <= prev_nxt;
      pend_r  <= pend_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

>>> rtl/touch_keyboard_chord_event_generator.sv
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | cev_pkg::in_t  (pads_pressed, mode_pad)
// out     | output    | out_valid / out_ready | cev_pkg::out_t (event_kind, note_number,
//         |           |                       |                 last_event)
// cfg     | input     | cfg_we                | cfg_index, cfg_wdata (no read-back)
//
// a request is taken in ST_IDLE, decided (mode pad, key combination or pad scan) in
// ST_DECIDE, then its note events leave ST_RUN one after another, each one waiting
// for room in the output register; the single shared adder forms every note and
// key value in turn
// in_ready is low from acceptance until the last event sits in the output register
// a stalled output register holds the sequencer in place; nothing is dropped
// reset (synchronous, rst_n low) sets the key to 60, clears the pad history,
// play mode and scale select, and empties the output register
module touch_keyboard_chord_event_generator (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cev_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cev_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [1:0]    cfg_wdata
);
  import cev_pkg::*;

  // configuration registers
  logic [1:0] play_mode_r;
  logic [1:0] scale_r;

  // output register
  logic       out_valid_r;
  out_t       out_r;

  // sequencer <-> shared adder
  alu_req_t   alu_req;
  alu_rsp_t   alu_rsp;
  logic       emit;
  out_t       emit_data;
  logic       slot_free;

  // output register may be refilled in the cycle it is drained
  assign slot_free = !out_valid_r || out_ready;

  cev_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .play_mode (play_mode_r),
    .scale     (scale_idx(scale_r)),
    .slot_free (slot_free),
    .emit      (emit),
    .emit_data (emit_data),
    .alu_req   (alu_req),
    .alu_rsp   (alu_rsp)
  );

  // one adder for key steps and every note offset
  cev_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_mode_r <= PM_DRUM;
      scale_r     <= SC_MAJOR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PLAY_MODE: play_mode_r <= cfg_wdata;
        CFG_SCALE:     scale_r     <= cfg_wdata;
        default:       play_mode_r <= play_mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_r <= emit_data;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // the sequencer never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> slot_free)
    else $error("result overwritten");

  // a reported key stays within the playable range
  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_kind == EV_KEY |->
      out_data.note_number >= KEY_LOW && out_data.note_number <= KEY_HIGH)
    else $error("key out of range");

  // mode pad and key events close their frame
  a_single_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_kind == EV_KEY || out_data.event_kind == EV_MODE)
      |-> out_data.last_event)
    else $error("single event frame not marked last");

endmodule
